/* design/cuqf_pkg.sv */
// Shared constants, codes, result struct and read-command table for the
// gas sensor UART query frame block. No dependencies.
package cuqf_pkg;

   // Input command codes (req_tuser)
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_BYTE  = 2'd2;

   // Result kinds (rsp_tuser)
   localparam logic KIND_TX      = 1'b0;
   localparam logic KIND_OUTCOME = 1'b1;

   // Outcome status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TIMEOUT   = 3'd1;
   localparam logic [2:0] ST_BAD_START = 3'd2;
   localparam logic [2:0] ST_CHECKSUM  = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   // Configuration register indexes
   localparam logic CSR_TIMEOUT_TICKS = 1'b0;
   localparam logic CSR_MAX_PPM       = 1'b1;

   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd200;
   localparam logic [15:0] MAX_PPM_RESET       = 16'd50000;

   // Frame layout: nine bytes, positions 0 to 8
   localparam logic [3:0] FRAME_LAST_POS = 4'd8;
   localparam logic [3:0] PPM_HIGH_POS   = 4'd2;
   localparam logic [3:0] PPM_LOW_POS    = 4'd3;
   localparam logic [7:0] START_BYTE     = 8'hFF;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [2:0]  status;
      logic [15:0] ppm;
   } result_type;

   typedef struct packed {
      logic        we;
      logic        index;
      logic [15:0] data;
   } csr_wr_type;

   // Fixed read command sent at the start of each query
   function automatic logic [7:0] read_cmd_byte(input logic [3:0] pos);
      logic [7:0] b;
      case (pos)
         4'd0:    b = 8'hFF;
         4'd1:    b = 8'h01;
         4'd2:    b = 8'h86;
         4'd8:    b = 8'h79;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* design/cuqf_tx_seq.sv */
// Transmit sequencer: walks the nine read-command bytes, one per free output slot.
// Depends on cuqf_pkg.
module cuqf_tx_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 advance,
   output logic                 busy,
   output logic                 tx_valid,
   output cuqf_pkg::result_type tx_res
);
   import cuqf_pkg::*;

   logic       busy_ff, busy_in;
   logic [3:0] pos_ff, pos_in;
   logic [3:0] cur_pos;

   // start loads byte 0 directly; the remaining bytes follow from pos_ff
   assign cur_pos  = busy_ff ? pos_ff : 4'd0;
   assign tx_valid = start || busy_ff;
   assign busy     = busy_ff;

   always_comb begin
      tx_res         = '0;
      tx_res.kind    = KIND_TX;
      tx_res.tx_byte = read_cmd_byte(cur_pos);
      tx_res.last    = (cur_pos == FRAME_LAST_POS);
      tx_res.status  = ST_OK;
   end

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (advance) begin
         if (start) begin
            busy_in = 1'b1;
            pos_in  = 4'd1;
         end else if (busy_ff) begin
            if (pos_ff == FRAME_LAST_POS) begin
               busy_in = 1'b0;
               pos_in  = 4'd0;
            end else begin
               pos_in = pos_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff != 4'd0 && pos_ff <= FRAME_LAST_POS))
      else $error("tx position out of frame while busy");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start)
      else $error("query start taken while command frame still going out");

endmodule

/* design/cuqf_engine.sv */
// Reply collector: configuration registers, byte count, running sum, timeout
// counter and outcome check. Depends on cuqf_pkg.
module cuqf_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  cuqf_pkg::csr_wr_type csr_wr,
   input  logic                 accept,
   input  logic [1:0]           command,
   input  logic [7:0]           rx_byte,
   output logic                 res_valid,
   output cuqf_pkg::result_type res
);
   import cuqf_pkg::*;

   logic [15:0] timeout_ticks_ff, timeout_ticks_in;
   logic [15:0] max_ppm_ff, max_ppm_in;
   logic        waiting_ff, waiting_in;
   logic [3:0]  bytes_ff, bytes_in;
   logic [7:0]  sum_ff, sum_in;
   logic        start_ok_ff, start_ok_in;
   logic [7:0]  ppm_hi_ff, ppm_hi_in;
   logic [7:0]  ppm_lo_ff, ppm_lo_in;
   logic [15:0] ticks_ff, ticks_in;

   logic [15:0] ticks_inc;
   logic [7:0]  expect_sum;
   logic [15:0] ppm_val;

   assign ticks_inc  = (ticks_ff == 16'hFFFF) ? ticks_ff : ticks_ff + 16'd1;
   assign expect_sum = ~sum_ff + 8'd1;
   assign ppm_val    = {ppm_hi_ff, ppm_lo_ff};

   always_comb begin
      timeout_ticks_in = timeout_ticks_ff;
      max_ppm_in       = max_ppm_ff;
      if (csr_wr.we) begin
         case (csr_wr.index)
            CSR_TIMEOUT_TICKS: timeout_ticks_in = csr_wr.data;
            CSR_MAX_PPM:       max_ppm_in       = csr_wr.data;
            default:           ;
         endcase
      end
   end

   always_comb begin
      waiting_in  = waiting_ff;
      bytes_in    = bytes_ff;
      sum_in      = sum_ff;
      start_ok_in = start_ok_ff;
      ppm_hi_in   = ppm_hi_ff;
      ppm_lo_in   = ppm_lo_ff;
      ticks_in    = ticks_ff;
      res_valid   = 1'b0;
      res         = '0;
      res.kind    = KIND_OUTCOME;
      res.last    = 1'b1;

      if (accept) begin
         case (command)
            CMD_START: begin
               waiting_in  = 1'b1;
               bytes_in    = 4'd0;
               sum_in      = 8'd0;
               start_ok_in = 1'b0;
               ppm_hi_in   = 8'd0;
               ppm_lo_in   = 8'd0;
               ticks_in    = 16'd0;
            end
            CMD_TICK: begin
               if (waiting_ff) begin
                  ticks_in = ticks_inc;
                  if (ticks_inc >= timeout_ticks_ff) begin
                     res_valid   = 1'b1;
                     res.status  = ST_TIMEOUT;
                     waiting_in  = 1'b0;
                     bytes_in    = 4'd0;
                     sum_in      = 8'd0;
                     start_ok_in = 1'b0;
                     ppm_hi_in   = 8'd0;
                     ppm_lo_in   = 8'd0;
                     ticks_in    = 16'd0;
                  end
               end
            end
            CMD_BYTE: begin
               if (waiting_ff) begin
                  if (bytes_ff == 4'd0) begin
                     start_ok_in = (rx_byte == START_BYTE);
                  end else if (bytes_ff != FRAME_LAST_POS) begin
                     sum_in = sum_ff + rx_byte;
                     if (bytes_ff == PPM_HIGH_POS) ppm_hi_in = rx_byte;
                     if (bytes_ff == PPM_LOW_POS)  ppm_lo_in = rx_byte;
                  end
                  if (bytes_ff != FRAME_LAST_POS) begin
                     bytes_in = bytes_ff + 4'd1;
                  end else begin
                     // ninth byte: checksum byte, give the outcome
                     res_valid = 1'b1;
                     if (!start_ok_ff) begin
                        res.status = ST_BAD_START;
                     end else if (expect_sum != rx_byte) begin
                        res.status = ST_CHECKSUM;
                     end else if (ppm_val > max_ppm_ff) begin
                        res.status = ST_RANGE;
                     end else begin
                        res.status = ST_OK;
                        res.ppm    = ppm_val;
                     end
                     waiting_in  = 1'b0;
                     bytes_in    = 4'd0;
                     sum_in      = 8'd0;
                     start_ok_in = 1'b0;
                     ppm_hi_in   = 8'd0;
                     ppm_lo_in   = 8'd0;
                     ticks_in    = 16'd0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= TIMEOUT_TICKS_RESET;
         max_ppm_ff       <= MAX_PPM_RESET;
         waiting_ff       <= 1'b0;
         bytes_ff         <= 4'd0;
         sum_ff           <= 8'd0;
         start_ok_ff      <= 1'b0;
         ppm_hi_ff        <= 8'd0;
         ppm_lo_ff        <= 8'd0;
         ticks_ff         <= 16'd0;
      end else begin
         timeout_ticks_ff <= timeout_ticks_in;
         max_ppm_ff       <= max_ppm_in;
         waiting_ff       <= waiting_in;
         bytes_ff         <= bytes_in;
         sum_ff           <= sum_in;
         start_ok_ff      <= start_ok_in;
         ppm_hi_ff        <= ppm_hi_in;
         ppm_lo_ff        <= ppm_lo_in;
         ticks_ff         <= ticks_in;
      end
   end

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !waiting_ff |-> (bytes_ff == 4'd0 && ticks_ff == 16'd0))
      else $error("exchange counters not cleared while idle");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      bytes_ff <= FRAME_LAST_POS)
      else $error("reply byte count beyond frame");

endmodule

/* design/cuqf_out_reg.sv */
// Result register between the block and the rsp stream; frees as it drains.
// Depends on cuqf_pkg.
module cuqf_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  cuqf_pkg::result_type load_res,
   input  logic                 rsp_tready,
   output logic                 rsp_valid,
   output cuqf_pkg::result_type rsp_res,
   output logic                 free
);
   import cuqf_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign free      = !valid_ff || rsp_tready;
   assign valid_in  = free ? load_valid : valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free) begin
         res_ff <= load_res;
      end
   end

   a_load_lands: assert property (@(posedge clock) disable iff (reset)
      (free && load_valid) |=> valid_ff)
      else $error("loaded result not held in output register");

endmodule

/* design/co2_sensor_uart_query_frame.sv */
// Top level of the gas sensor UART query frame block.
// Depends on cuqf_pkg, cuqf_tx_seq, cuqf_engine, cuqf_out_reg.
//
//   channel | direction | tdata / data                     | tuser   | tlast
//   req_    | in        | [7:0] rx_byte                    | command | -
//   rsp_    | out       | [7:0] tx_byte [10:8] status      | kind    | last
//           |           | [26:11] ppm, [31:27] zero        |         |
//   csr_    | in        | csr_index 0 timeout_ticks, 1 max_ppm, 16-bit csr_wdata
//
// Ticks and received bytes are taken one per cycle, back to back, while the
// output register is free and no command frame is going out; results appear in
// the rsp output register in the cycle after the transaction. A query start
// holds req_tready low after its transaction while the rest of the command
// frame leaves the transmit sequencer, one byte per free output slot.
// rsp_tready low stalls the output register and with it req_tready.
// Reset is synchronous; it restores the register defaults and goes idle.
module co2_sensor_uart_query_frame (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] tx_byte, [10:8] status, [26:11] ppm
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import cuqf_pkg::*;

   logic       accept;
   logic       start;
   logic       out_free;
   logic       tx_busy;
   logic       tx_valid;
   result_type tx_res;
   logic       eng_valid;
   result_type eng_res;
   logic       load_valid;
   result_type load_res;
   result_type out_res;
   csr_wr_type csr_wr;

   assign req_tready = out_free && !tx_busy;
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && (req_tuser == CMD_START);

   assign csr_wr.we    = csr_we;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_wdata;

   cuqf_tx_seq u_tx_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .advance  (out_free),
      .busy     (tx_busy),
      .tx_valid (tx_valid),
      .tx_res   (tx_res)
   );

   cuqf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_wr),
      .accept    (accept),
      .command   (req_tuser),
      .rx_byte   (req_tdata),
      .res_valid (eng_valid),
      .res       (eng_res)
   );

   // the engine never yields a result on a start, so the sources do not collide
   assign load_valid = tx_valid || eng_valid;
   assign load_res   = tx_valid ? tx_res : eng_res;

   cuqf_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load_res   (load_res),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_res    (out_res),
      .free       (out_free)
   );

   assign rsp_tdata = {5'd0, out_res.ppm, out_res.status, out_res.tx_byte};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last;

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      tx_busy |-> !req_tready)
      else $error("request taken during command frame");

endmodule
